@@ rtl/pmhb_pkg.sv @@
// shared types, op codes and angle table for the polar max-height binning block
package pmhb_pkg;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_NONE  = 2'd3;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_SHIFT = 20;

  typedef struct packed {
    logic [1:0]         op;
    logic signed [19:0] x_mm;
    logic signed [19:0] y_mm;
    logic signed [19:0] z_mm;
    logic [4:0]         ring_sel;
    logic [5:0]         sector_sel;
  } item_t;

  typedef struct packed {
    logic sweeping_init;
    logic take;
  } back_status_t;

  function automatic logic [31:0] atan_val(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h20000000;
      5'd1:  v = 32'h12E4051E;
      5'd2:  v = 32'h09FB385B;
      5'd3:  v = 32'h051111D4;
      5'd4:  v = 32'h028B0D43;
      5'd5:  v = 32'h0145D7E1;
      5'd6:  v = 32'h00A2F61E;
      5'd7:  v = 32'h00517C55;
      5'd8:  v = 32'h0028BE53;
      5'd9:  v = 32'h00145F2F;
      5'd10: v = 32'h000A2F98;
      5'd11: v = 32'h000517CC;
      5'd12: v = 32'h00028BE6;
      5'd13: v = 32'h000145F3;
      5'd14: v = 32'h0000A2FA;
      5'd15: v = 32'h0000517D;
      5'd16: v = 32'h000028BE;
      5'd17: v = 32'h0000145F;
      5'd18: v = 32'h00000A30;
      5'd19: v = 32'h00000518;
      5'd20: v = 32'h0000028C;
      5'd21: v = 32'h00000146;
      5'd22: v = 32'h000000A3;
      5'd23: v = 32'h00000051;
      5'd24: v = 32'h00000029;
      5'd25: v = 32'h00000014;
      5'd26: v = 32'h0000000A;
      5'd27: v = 32'h00000005;
      5'd28: v = 32'h00000003;
      5'd29: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

@@ rtl/pmhb_front.sv @@
// front end: accepts items, drops unused op codes and queues the rest
module pmhb_front import pmhb_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  output logic         busy,
  input  item_t        in_item,
  input  back_status_t status,
  output logic         q_valid,
  output item_t        q_item
);

  item_t      slot_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign busy    = (cnt_r == 2'd2) | status.sweeping_init;
  assign push    = start & ~busy & (in_item.op != OP_NONE);
  assign q_valid = (cnt_r != 2'd0);
  assign pop     = q_valid & status.take;
  assign q_item  = slot_r[rp_r];

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) slot_r[wp_r] <= in_item;
  end

endmodule

@@ rtl/pmhb_back.sv @@
// back end: grid memory, range and bearing units, ring sums and ring mean
module pmhb_back import pmhb_pkg::*; #(
  parameter int NUM_RINGS   = 20,
  parameter int NUM_SECTORS = 60
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_valid,
  input  item_t               q_item,
  output back_status_t        status,
  input  logic [17:0]         max_radius_mm,
  input  logic signed [14:0]  sensor_height_mm,
  output logic                res_valid,
  output logic signed [15:0]  res_height,
  output logic                res_filled,
  output logic signed [15:0]  res_mean
);

  localparam int DEPTH = NUM_RINGS * NUM_SECTORS;
  localparam int AW    = $clog2(DEPTH);
  localparam int RW    = (NUM_RINGS > 1) ? $clog2(NUM_RINGS) : 1;
  localparam int KW    = $clog2(NUM_RINGS + 1);
  localparam int SVW   = $clog2(NUM_SECTORS + 1);
  localparam int SUM_W = 16 + $clog2(NUM_SECTORS + 1);
  localparam int RCP_SH = SUM_W - 1 + SVW;
  localparam int RCW   = RCP_SH + 1;
  localparam int MPW   = SUM_W + RCW;
  localparam int RRW   = $clog2(NUM_RINGS * NUM_RINGS + 1);
  localparam int LW    = 37 + RRW;
  localparam int CXW   = 44;
  localparam int CZW   = 34;
  localparam int PW    = 33 + SVW;
  localparam logic [RRW-1:0]   RR     = RRW'(NUM_RINGS * NUM_RINGS);
  localparam logic [SVW-1:0]   NS     = SVW'(NUM_SECTORS);
  localparam logic [RCW-1:0]   RCP    = RCW'(((64'd1 << RCP_SH) + 64'(NUM_SECTORS) - 64'd1) /
                                             64'(NUM_SECTORS));

  localparam logic [3:0] ST_INIT = 4'd0;
  localparam logic [3:0] ST_IDLE = 4'd1;
  localparam logic [3:0] ST_CLR  = 4'd2;
  localparam logic [3:0] ST_MUL  = 4'd3;
  localparam logic [3:0] ST_CHK  = 4'd4;
  localparam logic [3:0] ST_RUN  = 4'd5;
  localparam logic [3:0] ST_SECT = 4'd6;
  localparam logic [3:0] ST_ADDR = 4'd7;
  localparam logic [3:0] ST_WAIT = 4'd8;
  localparam logic [3:0] ST_WR   = 4'd9;
  localparam logic [3:0] ST_DIV  = 4'd10;
  localparam logic [3:0] ST_OUT  = 4'd11;

  logic [3:0] state_r, state_nxt;

  // grid memory: {valid, height}
  logic [16:0] mem [DEPTH];
  logic [16:0] rdata_r;
  logic        mem_we;
  logic [AW-1:0] mem_wa;
  logic [16:0] mem_wd;

  logic signed [SUM_W-1:0] ring_sum_r [NUM_RINGS];
  logic        sum_we, sum_clr;
  logic signed [SUM_W-1:0] sum_wd;

  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [RW-1:0] ring_r, ring_nxt;
  logic [19:0]   ax_r, ax_nxt, ay_r, ay_nxt;
  logic          xneg_r, xneg_nxt, yneg_r, yneg_nxt;
  logic signed [15:0] h_r, h_nxt;
  logic [39:0]   ax2_r, ay2_r;
  logic [35:0]   m2_r;
  logic [LW-1:0] lhs_r, lhs_nxt, t_r, t_nxt, inc_r, inc_nxt;
  logic [KW-1:0] k_r, k_nxt;
  logic          rdone_r, rdone_nxt;
  logic signed [CXW-1:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [CZW-1:0] cz_r, cz_nxt;
  logic [4:0]    ci_r, ci_nxt;
  logic [SVW-1:0] sec_r, sec_nxt;
  logic [SUM_W-1:0] dq_r, dq_nxt;
  logic          mneg_r, mneg_nxt, oor_r, oor_nxt;
  logic          ov_r, ov_nxt;
  logic signed [15:0] oh_r, oh_nxt, om_r, om_nxt;
  logic          of_r, of_nxt;

  logic signed [20:0] hsum;
  logic [40:0]   d2;
  logic signed [CXW-1:0] dx, dy;
  logic signed [CZW-1:0] zstep;
  logic [31:0]   theta, aq;
  logic [PW-1:0] prod;
  logic [SVW-1:0] s_raw;
  logic [MPW-1:0] mprod;
  logic signed [SUM_W-1:0] cur_sum;
  logic [15:0]   qv;

  assign status.sweeping_init = (state_r == ST_INIT);
  assign status.take          = (state_r == ST_IDLE) & q_valid;
  assign res_valid  = ov_r;
  assign res_height = oh_r;
  assign res_filled = of_r;
  assign res_mean   = om_r;
  assign cur_sum    = ring_sum_r[ring_r];

  always_comb begin
    hsum  = 21'(q_item.z_mm) + 21'(sensor_height_mm);
    d2    = {1'b0, ax2_r} + {1'b0, ay2_r};
    dx    = cy_r >>> ci_r;
    dy    = cx_r >>> ci_r;
    zstep = CZW'($signed({1'b0, atan_val(ci_r)}));
    if (cz_r < 0)
      aq = 32'd0;
    else if (cz_r > CZW'(34'sh40000000))
      aq = 32'h40000000;
    else
      aq = cz_r[31:0];
    if (ay_r == 20'd0)
      theta = xneg_r ? 32'h80000000 : 32'h00000000;
    else if (ax_r == 20'd0)
      theta = yneg_r ? 32'hC0000000 : 32'h40000000;
    else if (!xneg_r && !yneg_r)
      theta = aq;
    else if (xneg_r && !yneg_r)
      theta = 32'h80000000 - aq;
    else if (xneg_r)
      theta = 32'h80000000 + aq;
    else
      theta = 32'h00000000 - aq;
    prod  = PW'(theta) * PW'(NS) + PW'(33'hFFFFFFFF);
    s_raw = prod[32 +: SVW];
    // ring sum magnitude over the sector count by reciprocal multiply
    mprod = MPW'(dq_r) * MPW'(RCP);
    qv = dq_r[15:0];
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt = cnt_r; addr_nxt = addr_r; ring_nxt = ring_r;
    ax_nxt = ax_r; ay_nxt = ay_r; xneg_nxt = xneg_r; yneg_nxt = yneg_r; h_nxt = h_r;
    lhs_nxt = lhs_r; t_nxt = t_r; inc_nxt = inc_r; k_nxt = k_r; rdone_nxt = rdone_r;
    cx_nxt = cx_r; cy_nxt = cy_r; cz_nxt = cz_r; ci_nxt = ci_r; sec_nxt = sec_r;
    dq_nxt = dq_r; mneg_nxt = mneg_r; oor_nxt = oor_r;
    ov_nxt = 1'b0; oh_nxt = oh_r; om_nxt = om_r; of_nxt = of_r;
    mem_we = 1'b0; mem_wa = cnt_r; mem_wd = 17'd0;
    sum_we = 1'b0; sum_clr = 1'b0; sum_wd = cur_sum;
    case (state_r)
      ST_INIT, ST_CLR: begin
        mem_we  = 1'b1;
        cnt_nxt = cnt_r + AW'(1);
        if (cnt_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (q_valid) begin
          case (q_item.op)
            OP_CLEAR: begin
              sum_clr   = 1'b1;
              cnt_nxt   = '0;
              state_nxt = ST_CLR;
            end
            OP_ADD: begin
              ax_nxt   = q_item.x_mm[19] ? 20'(-q_item.x_mm) : q_item.x_mm;
              ay_nxt   = q_item.y_mm[19] ? 20'(-q_item.y_mm) : q_item.y_mm;
              xneg_nxt = q_item.x_mm[19];
              yneg_nxt = q_item.y_mm[19];
              if (hsum > 21'sd32767)       h_nxt = 16'sh7FFF;
              else if (hsum < -21'sd32768) h_nxt = -16'sh8000;
              else                         h_nxt = hsum[15:0];
              state_nxt = ST_MUL;
            end
            OP_READ: begin
              oor_nxt = (32'(q_item.ring_sel) >= 32'(NUM_RINGS)) ||
                        (32'(q_item.sector_sel) >= 32'(NUM_SECTORS));
              ring_nxt = RW'(q_item.ring_sel);
              addr_nxt = AW'(32'(q_item.ring_sel) * NUM_SECTORS + 32'(q_item.sector_sel));
              state_nxt = oor_nxt ? ST_OUT : ST_DIV;
              if (!oor_nxt) begin
                mneg_nxt = ring_sum_r[RW'(q_item.ring_sel)][SUM_W-1];
                dq_nxt   = mneg_nxt ? SUM_W'(-ring_sum_r[RW'(q_item.ring_sel)])
                                    : SUM_W'(ring_sum_r[RW'(q_item.ring_sel)]);
              end
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_MUL: state_nxt = ST_CHK;
      ST_CHK: begin
        if (d2 > {5'd0, m2_r}) begin
          state_nxt = ST_IDLE;
        end else begin
          lhs_nxt   = LW'(d2) * LW'(RR);
          t_nxt     = LW'(m2_r);
          inc_nxt   = LW'(m2_r) * LW'(3);
          k_nxt     = KW'(1);
          rdone_nxt = 1'b0;
          cx_nxt    = CXW'(ax_r) << CORDIC_SHIFT;
          cy_nxt    = CXW'(ay_r) << CORDIC_SHIFT;
          cz_nxt    = '0;
          ci_nxt    = '0;
          state_nxt = ST_RUN;
        end
      end
      ST_RUN: begin
        if (ci_r != 5'(CORDIC_STEPS)) begin
          if (!cy_r[CXW-1]) begin
            cx_nxt = cx_r + dx; cy_nxt = cy_r - dy; cz_nxt = cz_r + zstep;
          end else begin
            cx_nxt = cx_r - dx; cy_nxt = cy_r + dy; cz_nxt = cz_r - zstep;
          end
          ci_nxt = ci_r + 5'd1;
        end
        if (!rdone_r) begin
          if ((k_r < KW'(NUM_RINGS)) && (lhs_r > t_r)) begin
            k_nxt   = k_r + KW'(1);
            t_nxt   = t_r + inc_r;
            inc_nxt = inc_r + LW'({m2_r, 1'b0});
          end else begin
            rdone_nxt = 1'b1;
          end
        end
        if ((ci_r == 5'(CORDIC_STEPS)) && rdone_r) state_nxt = ST_SECT;
      end
      ST_SECT: begin
        if (s_raw < SVW'(1))   sec_nxt = SVW'(1);
        else if (s_raw > NS)   sec_nxt = NS;
        else                   sec_nxt = s_raw;
        ring_nxt  = RW'(k_r - KW'(1));
        state_nxt = ST_ADDR;
      end
      ST_ADDR: begin
        addr_nxt  = AW'(32'(ring_r) * NUM_SECTORS + 32'(sec_r) - 32'd1);
        state_nxt = ST_WAIT;
      end
      ST_WAIT: state_nxt = ST_WR;
      ST_WR: begin
        mem_wa = addr_r;
        mem_wd = {1'b1, h_r};
        if (!rdata_r[16]) begin
          mem_we = 1'b1;
          sum_we = 1'b1;
          sum_wd = cur_sum + SUM_W'(h_r);
        end else if ($signed(rdata_r[15:0]) < h_r) begin
          mem_we = 1'b1;
          sum_we = 1'b1;
          sum_wd = cur_sum + SUM_W'(h_r) - SUM_W'($signed(rdata_r[15:0]));
        end
        state_nxt = ST_IDLE;
      end
      ST_DIV: begin
        dq_nxt    = SUM_W'(mprod[MPW-1:RCP_SH]);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        ov_nxt = 1'b1;
        if (oor_r) begin
          oh_nxt = '0; of_nxt = 1'b0; om_nxt = '0;
        end else begin
          of_nxt = rdata_r[16];
          oh_nxt = rdata_r[16] ? $signed(rdata_r[15:0]) : 16'sd0;
          om_nxt = mneg_r ? $signed(16'(-qv)) : $signed(qv);
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_INIT;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
      for (int i = 0; i < NUM_RINGS; i++) ring_sum_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      if (sum_clr) begin
        for (int i = 0; i < NUM_RINGS; i++) ring_sum_r[i] <= '0;
      end else if (sum_we) begin
        ring_sum_r[ring_r] <= sum_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt; ring_r <= ring_nxt;
    ax_r <= ax_nxt; ay_r <= ay_nxt; xneg_r <= xneg_nxt; yneg_r <= yneg_nxt; h_r <= h_nxt;
    ax2_r <= ax_r * ax_r;
    ay2_r <= ay_r * ay_r;
    m2_r  <= max_radius_mm * max_radius_mm;
    lhs_r <= lhs_nxt; t_r <= t_nxt; inc_r <= inc_nxt; k_r <= k_nxt; rdone_r <= rdone_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; cz_r <= cz_nxt; ci_r <= ci_nxt; sec_r <= sec_nxt;
    dq_r <= dq_nxt; mneg_r <= mneg_nxt; oor_r <= oor_nxt;
    oh_r <= oh_nxt; om_r <= om_nxt; of_r <= of_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    rdata_r <= mem[addr_r];
  end

endmodule

@@ rtl/polar_max_height_binning.sv @@
// top level of the polar max-height binning block: config registers, front and back
//
//   channel | direction | handshake              | payload
//   in_     | input     | start high, busy low   | op, x/y/z, ring and sector select
//   out_    | output    | out_valid, one cycle   | bin height, filled flag, ring mean
//   cfg     | input     | psel, penable, pwrite  | max radius, sensor height
//
// an add squares x and y, checks the range, runs the bearing loop with the ring search
// beside it, then forms the address, reads the bin and updates it
// a point beyond the radius leaves the back end after the range check
// a read scales the ring sum in the divide state, then out_valid is registered from the output state
// a clear sweeps the grid, one grid entry per cycle
// after reset a grid sweep runs with busy high; a two-item queue lets the input side
// run ahead and busy rises when it is full
module polar_max_height_binning import pmhb_pkg::*; #(
  parameter int NUM_RINGS   = 20,
  parameter int NUM_SECTORS = 60
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_op,
  input  logic signed [19:0] in_x_mm,
  input  logic signed [19:0] in_y_mm,
  input  logic signed [19:0] in_z_mm,
  input  logic [4:0]         in_ring_sel,
  input  logic [5:0]         in_sector_sel,
  output logic               out_valid,
  output logic signed [15:0] out_bin_height_mm,
  output logic               out_bin_filled,
  output logic signed [15:0] out_ring_mean_mm,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  logic [17:0]        max_radius_r;
  logic signed [14:0] sensor_height_r;
  logic               cfg_we;
  item_t              in_item, q_item;
  logic               q_valid;
  back_status_t       status;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite;
  assign prdata = paddr[2] ? 32'($signed(sensor_height_r)) : 32'(max_radius_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_radius_r    <= 18'd80000;
      sensor_height_r <= 15'sd2000;
    end else if (cfg_we) begin
      if (paddr[2]) sensor_height_r <= pwdata[14:0];
      else          max_radius_r    <= pwdata[17:0];
    end
  end

  assign in_item = '{op: in_op, x_mm: in_x_mm, y_mm: in_y_mm, z_mm: in_z_mm,
                     ring_sel: in_ring_sel, sector_sel: in_sector_sel};

  pmhb_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .busy    (busy),
    .in_item (in_item),
    .status  (status),
    .q_valid (q_valid),
    .q_item  (q_item)
  );

  pmhb_back #(
    .NUM_RINGS   (NUM_RINGS),
    .NUM_SECTORS (NUM_SECTORS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_item           (q_item),
    .status           (status),
    .max_radius_mm    (max_radius_r),
    .sensor_height_mm (sensor_height_r),
    .res_valid        (out_valid),
    .res_height       (out_bin_height_mm),
    .res_filled       (out_bin_filled),
    .res_mean         (out_ring_mean_mm)
  );

endmodule

@@ rtl/pmhb_checker.sv @@
// port-level checks for the polar max-height binning block
module pmhb_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               busy,
  input logic               out_valid,
  input logic               out_bin_filled,
  input logic signed [15:0] out_bin_height_mm,
  input logic               pready
);

  // reset starts the grid sweep
  a_busy_after_reset: assert property (@(posedge clk) !rst_n |=> busy)
    else $error("busy low right after reset");

  // an empty bin reads as zero height
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_bin_filled) |-> (out_bin_height_mm == 16'sd0))
    else $error("empty bin with nonzero height");

  // each read passes through the idle state again before its output state, so strobes never touch
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobes back to back");

  a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
    else $error("pready low");

endmodule

bind polar_max_height_binning pmhb_checker u_pmhb_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .busy              (busy),
  .out_valid         (out_valid),
  .out_bin_filled    (out_bin_filled),
  .out_bin_height_mm (out_bin_height_mm),
  .pready            (pready)
);
